// File: hw/rtl/gdop_pkg.sv
// Shared constants and types for the GPIO debounce and output pattern block.
// No dependencies; every other file refers to this package by scoped names.
package gdop_pkg;

    localparam int PIN_COUNT  = 16;
    localparam int WORD_W     = 16;
    localparam int LANE_COUNT = (PIN_COUNT > WORD_W) ? WORD_W : PIN_COUNT;

    localparam int TIME_W  = 32;
    localparam int MODE_W  = 3;
    localparam int MODES_W = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS   = 2'd2;

    localparam logic [WORD_W-1:0]  INPUT_MASK_RST  = 16'hFFFF;
    localparam logic [MODES_W-1:0] OUTPUT_MODES_RST = 48'h0;
    localparam logic [WORD_W-1:0]  SETTLE_MS_RST   = 16'd50;

    // Per-pin output modes
    localparam logic [MODE_W-1:0] MODE_NONE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OFF        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ON         = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLINK_SLOW = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BLINK_FAST = 3'd4;

    // Blink phase = parity of now/500 and now/200.
    // now/500 = (now>>2)/125, exact via reciprocal 2^37/125 rounded up.
    // now/200 = (now>>3)/25,  exact via reciprocal 2^34/25 rounded up.
    localparam int SLOW_X_W     = 30;
    localparam int SLOW_SHIFT   = 37;
    localparam int SLOW_PROD_W  = 61;
    localparam logic [30:0] SLOW_RECIP = 31'd1099511628;
    localparam int FAST_X_W     = 29;
    localparam int FAST_SHIFT   = 34;
    localparam int FAST_PROD_W  = 59;
    localparam logic [29:0] FAST_RECIP = 30'd687194768;

    // Per-lane item slice
    typedef struct packed {
        logic                 step;
        logic                 is_input;
        logic [MODE_W-1:0]    mode;
        logic                 sample;
        logic                 wr_mask;
        logic                 wr_value;
    } t_lane_in;

    // Per-lane result
    typedef struct packed {
        logic latch;
        logic stable;
        logic change;
        logic press;
    } t_lane_res;

endpackage

// File: hw/rtl/gdop_in_if.sv
// Input channel: one tick transaction (time, pin sample, software writes).
// Depends on gdop_pkg for widths.
interface gdop_in_if;
    logic                            valid;
    logic                            ready;
    logic [gdop_pkg::TIME_W-1:0]     now_ms;
    logic                            sample_valid;
    logic [gdop_pkg::WORD_W-1:0]     gpio_sample;
    logic [gdop_pkg::WORD_W-1:0]     write_mask;
    logic [gdop_pkg::WORD_W-1:0]     write_values;

    modport source (output valid, now_ms, sample_valid, gpio_sample, write_mask,
                    write_values, input ready);
    modport sink   (input valid, now_ms, sample_valid, gpio_sample, write_mask,
                    write_values, output ready);
endinterface

// File: hw/rtl/gdop_out_if.sv
// Output channel: one result transaction per tick.
// Depends on gdop_pkg for widths.
interface gdop_out_if;
    logic                        valid;
    logic                        ready;
    logic [gdop_pkg::WORD_W-1:0] latch_word;
    logic [gdop_pkg::WORD_W-1:0] stable_levels;
    logic [gdop_pkg::WORD_W-1:0] change_events;
    logic [gdop_pkg::WORD_W-1:0] press_events;

    modport source (output valid, latch_word, stable_levels, change_events,
                    press_events, input ready);
    modport sink   (input valid, latch_word, stable_levels, change_events,
                    press_events, output ready);
endinterface

// File: hw/rtl/gpio_debounce_and_output_pattern.sv
// Top level of the GPIO debounce and output pattern block.
// Depends on gdop_pkg, gdop_in_if, gdop_out_if, gdop_phase and gdop_lane.
//
// Usage
//   i_req  : one transaction per millisecond tick: now_ms, sample_valid,
//            gpio_sample, write_mask, write_values. Taken when valid && ready.
//   o_rsp  : one transaction per tick: latch_word, stable_levels,
//            change_events, press_events, in tick order.
//   i_cfg_*: register write port (0 input_mask, 1 output_modes,
//            2 settle time in ms); index 3 is ignored. Write only while idle.
// Timing
//   Two register stages: the blink phase multipliers, then sixteen pin lanes
//   whose bits are merged into the output register. A taken tick is held in
//   the first stage until the output register frees, then moves into it and
//   is offered on o_rsp; one tick is taken every cycle while the receiver
//   keeps up.
// Reset (synchronous, active low)
//   Empties both stages, restores register defaults, raw and debounced
//   levels all ones, cached sample zero and change timestamps zero.
// Stall
//   While o_rsp is held, the output register keeps its transaction and the
//   first stage can still take one more tick; i_req.ready then drops.
module gpio_debounce_and_output_pattern (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    gdop_in_if.sink                            i_req,
    gdop_out_if.source                         o_rsp,
    input  logic                               i_cfg_wr_en,
    input  logic [gdop_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gdop_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    // configuration
    logic [gdop_pkg::WORD_W-1:0]  r_input_mask;
    logic [gdop_pkg::MODES_W-1:0] r_output_modes;
    logic [gdop_pkg::WORD_W-1:0]  r_settle_ms;

    // first stage
    logic                         r_s1_valid;
    logic [gdop_pkg::TIME_W-1:0]  r_s1_now;
    logic                         r_s1_sample_valid;
    logic [gdop_pkg::WORD_W-1:0]  r_s1_sample;
    logic [gdop_pkg::WORD_W-1:0]  r_s1_wmask;
    logic [gdop_pkg::WORD_W-1:0]  r_s1_wvals;
    logic                         w_slow_high;
    logic                         w_fast_high;

    // lane stage and output register
    logic [gdop_pkg::WORD_W-1:0]  r_cached;
    logic [gdop_pkg::WORD_W-1:0]  n_cached;
    logic                         r_out_valid;
    logic [gdop_pkg::WORD_W-1:0]  r_out_latch;
    logic [gdop_pkg::WORD_W-1:0]  r_out_stable;
    logic [gdop_pkg::WORD_W-1:0]  r_out_change;
    logic [gdop_pkg::WORD_W-1:0]  r_out_press;
    logic [gdop_pkg::WORD_W-1:0]  n_latch;
    logic [gdop_pkg::WORD_W-1:0]  n_stable;
    logic [gdop_pkg::WORD_W-1:0]  n_change;
    logic [gdop_pkg::WORD_W-1:0]  n_press;

    logic w_advance;
    logic w_take;
    logic w_step;

    gdop_pkg::t_lane_in  w_lane_in  [gdop_pkg::LANE_COUNT];
    gdop_pkg::t_lane_res w_lane_res [gdop_pkg::LANE_COUNT];

    // Handshake: the output register frees when empty or taken.
    assign w_advance   = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || w_advance;
    assign w_take      = i_req.valid && i_req.ready;
    assign w_step      = r_s1_valid && w_advance;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_mask   <= gdop_pkg::INPUT_MASK_RST;
            r_output_modes <= gdop_pkg::OUTPUT_MODES_RST;
            r_settle_ms    <= gdop_pkg::SETTLE_MS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                gdop_pkg::CFG_INPUT_MASK: begin
                    r_input_mask <= i_cfg_wdata[gdop_pkg::WORD_W-1:0];
                end
                gdop_pkg::CFG_OUTPUT_MODES: begin
                    r_output_modes <= i_cfg_wdata[gdop_pkg::MODES_W-1:0];
                end
                gdop_pkg::CFG_SETTLE_MS: begin
                    r_settle_ms <= i_cfg_wdata[gdop_pkg::WORD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // First stage: tick payload and blink phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_now          <= i_req.now_ms;
            r_s1_sample_valid <= i_req.sample_valid;
            r_s1_sample       <= i_req.gpio_sample;
            r_s1_wmask        <= i_req.write_mask;
            r_s1_wvals        <= i_req.write_values;
        end
    end

    gdop_phase u_phase (
        .i_clk       (i_clk),
        .i_load      (w_take),
        .i_now       (i_req.now_ms),
        .o_slow_high (w_slow_high),
        .o_fast_high (w_fast_high)
    );

    // Last good sample stands in for a failed read
    assign n_cached = r_s1_sample_valid ? r_s1_sample : r_cached;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cached <= '0;
        end else if (w_step) begin
            r_cached <= n_cached;
        end
    end

    // Pin lanes
    for (genvar g = 0; g < gdop_pkg::LANE_COUNT; g++) begin : g_lane
        assign w_lane_in[g].step     = w_step;
        assign w_lane_in[g].is_input = r_input_mask[g];
        assign w_lane_in[g].mode     = r_output_modes[g*gdop_pkg::MODE_W +: gdop_pkg::MODE_W];
        assign w_lane_in[g].sample   = n_cached[g];
        assign w_lane_in[g].wr_mask  = r_s1_wmask[g];
        assign w_lane_in[g].wr_value = r_s1_wvals[g];

        gdop_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_lane        (w_lane_in[g]),
            .i_now         (r_s1_now),
            .i_settle_ms   (r_settle_ms),
            .i_slow_high   (w_slow_high),
            .i_fast_high   (w_fast_high),
            .o_res         (w_lane_res[g])
        );
    end

    // Merge lane bits into result words; unused pins keep reset levels
    always_comb begin
        n_latch  = '0;
        n_stable = '1;
        n_change = '0;
        n_press  = '0;
        for (int k = 0; k < gdop_pkg::LANE_COUNT; k++) begin
            n_latch[k]  = w_lane_res[k].latch;
            n_stable[k] = w_lane_res[k].stable;
            n_change[k] = w_lane_res[k].change;
            n_press[k]  = w_lane_res[k].press;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_latch  <= n_latch;
            r_out_stable <= n_stable;
            r_out_change <= n_change;
            r_out_press  <= n_press;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.latch_word    = r_out_latch;
    assign o_rsp.stable_levels = r_out_stable;
    assign o_rsp.change_events = r_out_change;
    assign o_rsp.press_events  = r_out_press;

`ifndef SYNTHESIS
    // a press is always also a change
    a_press_is_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_press & ~r_out_change) == '0))
        else $error("press event without change event");

    // a press leaves the debounced level low
    a_press_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_press & r_out_stable) == '0))
        else $error("press event with high debounced level");

    // events only on input pins, whose latch bits are zero
    a_event_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_change & r_out_latch) == '0))
        else $error("change event on a driven pin");

    // a taken tick reaches the first stage
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_s1_valid)
        else $error("accepted transaction lost in first stage");

    // a held result is not overwritten
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out_stable)))
        else $error("stalled result changed");
`endif
endmodule

// File: hw/rtl/gdop_phase.sv
// Blink phase unit: registers the 500 ms and 200 ms blink levels of a timestamp.
// Depends on gdop_pkg (reciprocal constants).
module gdop_phase (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [gdop_pkg::TIME_W-1:0]   i_now,
    output logic                          o_slow_high,
    output logic                          o_fast_high
);
    logic [gdop_pkg::SLOW_PROD_W-1:0] w_prod_slow;
    logic [gdop_pkg::FAST_PROD_W-1:0] w_prod_fast;
    logic r_slow_high;
    logic r_fast_high;

    assign w_prod_slow = gdop_pkg::SLOW_PROD_W'(i_now[gdop_pkg::TIME_W-1:2])
                       * gdop_pkg::SLOW_PROD_W'(gdop_pkg::SLOW_RECIP);
    assign w_prod_fast = gdop_pkg::FAST_PROD_W'(i_now[gdop_pkg::TIME_W-1:3])
                       * gdop_pkg::FAST_PROD_W'(gdop_pkg::FAST_RECIP);

    // high while the quotient is even
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slow_high <= ~w_prod_slow[gdop_pkg::SLOW_SHIFT];
            r_fast_high <= ~w_prod_fast[gdop_pkg::FAST_SHIFT];
        end
    end

    assign o_slow_high = r_slow_high;
    assign o_fast_high = r_fast_high;
endmodule

// File: hw/rtl/gdop_lane.sv
// One pin lane: raw level, debounced level and change timestamp of one pin,
// plus its output drive. Depends on gdop_pkg (t_lane_in, t_lane_res, modes).
module gdop_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gdop_pkg::t_lane_in            i_lane,
    input  logic [gdop_pkg::TIME_W-1:0]   i_now,
    input  logic [gdop_pkg::WORD_W-1:0]   i_settle_ms,
    input  logic                          i_slow_high,
    input  logic                          i_fast_high,
    output gdop_pkg::t_lane_res           o_res
);
    logic                        r_raw;
    logic                        r_stable;
    logic [gdop_pkg::TIME_W-1:0] r_change_time;
    logic                        n_stable;
    logic [gdop_pkg::TIME_W-1:0] n_change_time;
    logic [gdop_pkg::TIME_W-1:0] w_elapsed;
    logic                        w_accept;
    logic                        w_drive;
    logic                        w_drive_level;

    // output drive: mode overrides software write
    always_comb begin
        w_drive       = i_lane.wr_mask;
        w_drive_level = i_lane.wr_value;
        case (i_lane.mode)
            gdop_pkg::MODE_OFF: begin
                w_drive = 1'b1;
                w_drive_level = 1'b0;
            end
            gdop_pkg::MODE_ON: begin
                w_drive = 1'b1;
                w_drive_level = 1'b1;
            end
            gdop_pkg::MODE_BLINK_SLOW: begin
                w_drive = 1'b1;
                w_drive_level = i_slow_high;
            end
            gdop_pkg::MODE_BLINK_FAST: begin
                w_drive = 1'b1;
                w_drive_level = i_fast_high;
            end
            default: begin
                w_drive       = i_lane.wr_mask;
                w_drive_level = i_lane.wr_value;
            end
        endcase
    end

    // debounce
    assign n_change_time = (i_lane.is_input && (i_lane.sample != r_raw)) ? i_now
                                                                        : r_change_time;
    assign w_elapsed = i_now - n_change_time;
    assign w_accept  = i_lane.is_input && (r_stable != i_lane.sample)
                     && (w_elapsed > gdop_pkg::TIME_W'(i_settle_ms));

    always_comb begin
        n_stable = r_stable;
        if (i_lane.is_input) begin
            if (w_accept) begin
                n_stable = i_lane.sample;
            end
        end else if (w_drive) begin
            n_stable = w_drive_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw         <= 1'b1;
            r_stable      <= 1'b1;
            r_change_time <= '0;
        end else if (i_lane.step) begin
            r_raw         <= i_lane.sample;
            r_stable      <= n_stable;
            r_change_time <= n_change_time;
        end
    end

    assign o_res.latch  = i_lane.is_input ? 1'b0
                        : (w_drive ? w_drive_level : i_lane.sample);
    assign o_res.stable = n_stable;
    assign o_res.change = w_accept;
    assign o_res.press  = w_accept && !i_lane.sample;
endmodule
